[design/urpm_pkg.sv]
// Shared types and constants of the URI-Path route matcher.
package urpm_pkg;

  localparam int unsigned MaxRoutesDefault  = 8;
  localparam int unsigned MaxPathLenDefault = 32;
  localparam int unsigned IndexWidth        = 3;
  localparam logic [7:0]  SlashByte         = 8'h2F;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_COMMIT    = 3'd1,
    OP_SEG_BEGIN = 3'd2,
    OP_SEG_BYTE  = 3'd3,
    OP_MSG_END   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_e;

  // Matching command broadcast to every table entry.
  typedef struct packed {
    logic       seg_begin;
    logic       seg_byte;
    logic       msg_end;
    logic       seg_open;
    logic [7:0] data_byte;
  } urpm_ctrl_t;

  // Per-entry flags returned to the selection logic.
  typedef struct packed {
    logic dup_hit;
    logic match;
  } urpm_stat_t;

endpackage

[design/uri_path_route_matcher.sv]
// URI-Path route matcher top level: input register, route table and result register.
// The block holds up to MAX_ROUTES route paths of up to MAX_PATH_LEN bytes, each
// with an 8-bit handler id. A path is registered by streaming its bytes with the
// load operation and then issuing commit with the handler id; committing a path
// that is already in the table only replaces its handler, a full table answers
// with status table full and an overlong path with status path too long. URI-Path
// segments of a message are matched by segment begin, segment byte and message
// end words; every table entry tracks its own offset and alive flag, so all routes
// are checked in parallel, and message end returns the lowest live entry whose
// path is fully consumed, then rearms all entries for the next message. Every
// input word yields exactly one result word. Each word is held in the input
// register, then the table update and result formation load the result register,
// and a new word is accepted every cycle as long as the result register drains;
// throughput is bounded by the single table update per cycle. No clearing pass
// is needed after reset.
module uri_path_route_matcher #(
  parameter int unsigned MAX_ROUTES   = urpm_pkg::MaxRoutesDefault,
  parameter int unsigned MAX_PATH_LEN = urpm_pkg::MaxPathLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] handler_id
  input  logic [2:0]  s_axis_tuser,   // [2:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] found_handler, [10:8] entry_index, rest zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned CW  = $clog2(MAX_ROUTES + 1);
  localparam int unsigned IW  = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int unsigned SLW = $clog2(MAX_PATH_LEN + 2);
  localparam int unsigned XW  = urpm_pkg::IndexWidth;

  // Input register.
  logic              in_valid_q;
  urpm_pkg::op_e     op_q;
  logic [7:0]        byte_q;
  logic [7:0]        hid_q;

  // Result register.
  logic              out_valid_q;
  urpm_pkg::status_e status_q, status_d;
  logic [7:0]        found_q, found_d;
  logic [XW-1:0]     index_q, index_d;

  // Table control state.
  logic [CW-1:0]     count_q, count_d;
  logic              seg_open_q, seg_open_d;

  logic              advance;
  logic              fire;

  logic                         stage_load, stage_clear, stage_full;
  logic [MAX_PATH_LEN-1:0][7:0] stage_bytes;
  logic [SLW-1:0]               stage_len;

  urpm_pkg::urpm_ctrl_t                   ctrl;
  urpm_pkg::urpm_stat_t [MAX_ROUTES-1:0]  stats;
  logic [MAX_ROUTES-1:0][7:0]             handlers;
  logic [MAX_ROUTES-1:0]                  active, wr_row, wr_handler;

  logic          too_long, table_full, commit_ok;
  logic          dup_any, match_any;
  logic [IW-1:0] dup_idx, match_idx;

  // The result register frees when it is empty or being read; the input register
  // then hands its word on, so a new word can enter in the same cycle.
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q   <= urpm_pkg::op_e'(s_axis_tuser);
      byte_q <= s_axis_tdata[7:0];
      hid_q  <= s_axis_tdata[15:8];
    end
  end

  // Staging buffer for path registration.
  assign stage_load  = fire && (op_q == urpm_pkg::OP_LOAD);
  assign stage_clear = fire && (op_q == urpm_pkg::OP_COMMIT);

  urpm_staging #(
    .MAX_PATH_LEN(MAX_PATH_LEN)
  ) u_staging (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (stage_load),
    .clear_i(stage_clear),
    .byte_i (byte_q),
    .bytes_o(stage_bytes),
    .len_o  (stage_len),
    .full_o (stage_full)
  );

  // Command broadcast to all entries; only a word that moves on changes anything.
  always_comb begin
    ctrl           = '0;
    ctrl.seg_open  = seg_open_q;
    ctrl.data_byte = byte_q;
    ctrl.seg_begin = fire && (op_q == urpm_pkg::OP_SEG_BEGIN);
    ctrl.seg_byte  = fire && (op_q == urpm_pkg::OP_SEG_BYTE);
    ctrl.msg_end   = fire && (op_q == urpm_pkg::OP_MSG_END);
  end

  // Lowest-index selection for both duplicate hits and final matches.
  always_comb begin
    dup_any   = 1'b0;
    dup_idx   = '0;
    match_any = 1'b0;
    match_idx = '0;
    for (int i = MAX_ROUTES - 1; i >= 0; i--) begin
      if (stats[i].dup_hit) begin
        dup_any = 1'b1;
        dup_idx = IW'(i);
      end
      if (stats[i].match) begin
        match_any = 1'b1;
        match_idx = IW'(i);
      end
    end
  end

  // An overlong path wins over a full table; a full table blocks even a duplicate.
  assign too_long   = (stage_len > SLW'(MAX_PATH_LEN));
  assign table_full = (count_q >= CW'(MAX_ROUTES));
  assign commit_ok  = stage_clear && !too_long && !table_full;

  always_comb begin
    for (int i = 0; i < MAX_ROUTES; i++) begin
      active[i]     = (CW'(i) < count_q);
      wr_row[i]     = commit_ok && !dup_any && (CW'(i) == count_q);
      wr_handler[i] = commit_ok && (dup_any ? (IW'(i) == dup_idx) : (CW'(i) == count_q));
    end
  end

  for (genvar g = 0; g < MAX_ROUTES; g++) begin : g_entry
    urpm_entry #(
      .MAX_PATH_LEN(MAX_PATH_LEN)
    ) u_entry (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .active_i     (active[g]),
      .wr_row_i     (wr_row[g]),
      .wr_handler_i (wr_handler[g]),
      .handler_i    (hid_q),
      .stage_bytes_i(stage_bytes),
      .stage_len_i  (stage_len),
      .stat_o       (stats[g]),
      .handler_o    (handlers[g])
    );
  end

  // Control state and result formation.
  always_comb begin
    count_d    = count_q;
    seg_open_d = seg_open_q;
    status_d   = urpm_pkg::ST_OK;
    found_d    = '0;
    index_d    = '0;
    unique case (op_q)
      urpm_pkg::OP_LOAD: begin
        if (stage_full) begin
          status_d = urpm_pkg::ST_TOO_LONG;
        end
      end
      urpm_pkg::OP_COMMIT: begin
        if (too_long) begin
          status_d = urpm_pkg::ST_TOO_LONG;
        end else if (table_full) begin
          status_d = urpm_pkg::ST_FULL;
        end else if (dup_any) begin
          index_d = XW'(dup_idx);
        end else begin
          index_d = XW'(count_q);
          count_d = count_q + CW'(1);
        end
      end
      urpm_pkg::OP_SEG_BEGIN: begin
        seg_open_d = 1'b1;
      end
      urpm_pkg::OP_SEG_BYTE: begin
        seg_open_d = seg_open_q;
      end
      urpm_pkg::OP_MSG_END: begin
        seg_open_d = 1'b0;
        if (match_any) begin
          found_d = handlers[match_idx];
          index_d = XW'(match_idx);
        end else begin
          status_d = urpm_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        // Unused operation codes leave everything as it is and report ok.
        status_d = urpm_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      seg_open_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q    <= count_d;
        seg_open_q <= seg_open_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      found_q  <= found_d;
      index_q  <= index_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {{(16 - 8 - XW){1'b0}}, index_q, found_q};

  // A fresh path that is neither overlong, blocked nor a duplicate grows the table by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_ok && !dup_any |=> count_q == $past(count_q) + CW'(1))
    else $error("route count did not advance on a new path");

  // At most one entry takes a handler per commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_handler))
    else $error("more than one entry written on commit");

  // A miss carries neither a handler nor an index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == urpm_pkg::ST_NOT_FOUND |-> found_q == '0 && index_q == '0)
    else $error("not-found result carries data");

  // Message end always leaves no segment open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && op_q == urpm_pkg::OP_MSG_END |=> !seg_open_q)
    else $error("segment still open after message end");

  // The table never holds more routes than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> count_q <= CW'(MAX_ROUTES))
    else $error("route count beyond table size");

endmodule

[design/urpm_staging.sv]
// Staging buffer that collects the bytes of a path being registered.
module urpm_staging #(
  parameter int unsigned MAX_PATH_LEN = urpm_pkg::MaxPathLenDefault,
  localparam int unsigned SLW = $clog2(MAX_PATH_LEN + 2),
  localparam int unsigned AW  = (MAX_PATH_LEN > 1) ? $clog2(MAX_PATH_LEN) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic                         clear_i,
  input  logic [7:0]                   byte_i,
  output logic [MAX_PATH_LEN-1:0][7:0] bytes_o,
  output logic [SLW-1:0]               len_o,
  output logic                         full_o
);

  logic [MAX_PATH_LEN-1:0][7:0] bytes_q;
  logic [SLW-1:0]               len_q, len_d;

  assign full_o  = (len_q >= SLW'(MAX_PATH_LEN));
  assign bytes_o = bytes_q;
  assign len_o   = len_q;

  always_comb begin
    len_d = len_q;
    if (clear_i) begin
      len_d = '0;
    end else if (load_i) begin
      // Once full, the length parks one past the limit so commit sees the overflow.
      len_d = full_o ? SLW'(MAX_PATH_LEN + 1) : len_q + SLW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && !full_o) begin
      bytes_q[len_q[AW-1:0]] <= byte_i;
    end
  end

endmodule

[design/urpm_entry.sv]
// One route table entry: stored path, handler and its match tracking.
module urpm_entry #(
  parameter int unsigned MAX_PATH_LEN = urpm_pkg::MaxPathLenDefault,
  localparam int unsigned SLW = $clog2(MAX_PATH_LEN + 2),
  localparam int unsigned LW  = $clog2(MAX_PATH_LEN + 1),
  localparam int unsigned AW  = (MAX_PATH_LEN > 1) ? $clog2(MAX_PATH_LEN) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  urpm_pkg::urpm_ctrl_t         ctrl_i,
  input  logic                         active_i,
  input  logic                         wr_row_i,
  input  logic                         wr_handler_i,
  input  logic [7:0]                   handler_i,
  input  logic [MAX_PATH_LEN-1:0][7:0] stage_bytes_i,
  input  logic [SLW-1:0]               stage_len_i,
  output urpm_pkg::urpm_stat_t         stat_o,
  output logic [7:0]                   handler_o
);

  logic [MAX_PATH_LEN-1:0][7:0] row_q;
  logic [LW-1:0]                len_q;
  logic [7:0]                   handler_q;
  logic [LW-1:0]                off_q, off_d, off_closed;
  logic                         alive_q, alive_d, alive_closed;
  logic [7:0]                   cur_byte;
  logic                         in_path;
  logic                         mismatch;

  assign in_path  = (off_q < len_q);
  assign cur_byte = row_q[off_q[AW-1:0]];

  // Closing an open segment: a slash is skipped, otherwise the path must be used up.
  always_comb begin
    off_closed   = off_q;
    alive_closed = alive_q;
    if (ctrl_i.seg_open && active_i && alive_q && in_path) begin
      if (cur_byte == urpm_pkg::SlashByte) begin
        off_closed = off_q + LW'(1);
      end else begin
        alive_closed = 1'b0;
      end
    end
  end

  always_comb begin
    off_d   = off_q;
    alive_d = alive_q;
    if (ctrl_i.msg_end) begin
      off_d   = '0;
      alive_d = 1'b1;
    end else if (ctrl_i.seg_begin && active_i) begin
      off_d   = off_closed;
      alive_d = alive_closed && (off_closed < len_q);
    end else if (ctrl_i.seg_byte && ctrl_i.seg_open && active_i && alive_q) begin
      if (!in_path || cur_byte == urpm_pkg::SlashByte || cur_byte != ctrl_i.data_byte) begin
        alive_d = 1'b0;
      end else begin
        off_d = off_q + LW'(1);
      end
    end
  end

  // Duplicate check against the staged path, over the stored length only.
  always_comb begin
    mismatch = 1'b0;
    for (int j = 0; j < MAX_PATH_LEN; j++) begin
      if (LW'(j) < len_q && row_q[j] != stage_bytes_i[j]) begin
        mismatch = 1'b1;
      end
    end
  end

  assign stat_o.dup_hit = active_i && (stage_len_i == SLW'(len_q)) && !mismatch;
  assign stat_o.match   = active_i && alive_closed && (off_closed == len_q);
  assign handler_o      = handler_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      alive_q <= 1'b1;
    end else begin
      off_q   <= off_d;
      alive_q <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_row_i) begin
      row_q <= stage_bytes_i;
      len_q <= stage_len_i[LW-1:0];
    end
    if (wr_handler_i) begin
      handler_q <= handler_i;
    end
  end

endmodule

[sim/tb_uri_path_route_matcher.sv]
// Testbench of the URI-Path route matcher: directed and random words checked against a model.
`timescale 1ns / 1ps

typedef struct packed {
  urpm_pkg::status_e status;
  logic [7:0]        handler;
  logic [2:0]        index;
} route_reply_t;

class route_scoreboard;
  localparam int unsigned Routes  = urpm_pkg::MaxRoutesDefault;
  localparam int unsigned PathLen = urpm_pkg::MaxPathLenDefault;

  logic [7:0]   path_mem [Routes][PathLen];
  int unsigned  path_len [Routes];
  logic [7:0]   path_handler [Routes];
  int unsigned  route_cnt;
  logic [7:0]   stage_mem [PathLen];
  int unsigned  stage_len;
  int unsigned  offs [Routes];
  bit           alive [Routes];
  bit           seg_open;
  route_reply_t expected_replies [$];
  int unsigned  errors, replies_checked, hits, misses, full_replies, too_long_replies;

  function new();
    route_cnt = 0;
    stage_len = 0;
    errors = 0;
    replies_checked = 0;
    hits = 0;
    misses = 0;
    full_replies = 0;
    too_long_replies = 0;
    rearm_entries();
  endfunction

  function void rearm_entries();
    for (int i = 0; i < Routes; i++) begin
      offs[i]  = 0;
      alive[i] = 1'b1;
    end
    seg_open = 1'b0;
  endfunction

  // Closing a segment skips a slash in the path or requires the path's end.
  function void end_segment();
    if (!seg_open) return;
    for (int i = 0; i < route_cnt; i++) begin
      if (alive[i] && offs[i] < path_len[i]) begin
        if (path_mem[i][offs[i]] == urpm_pkg::SlashByte) offs[i]++;
        else alive[i] = 1'b0;
      end
    end
    seg_open = 1'b0;
  endfunction

  // Applies one accepted input word to the table copy and queues the reply it causes.
  function void apply_word(logic [2:0] op_bits, logic [7:0] b, logic [7:0] h);
    route_reply_t r;
    int unsigned  len;
    int           dup;
    bit           same;
    r.status  = urpm_pkg::ST_OK;
    r.handler = '0;
    r.index   = '0;
    dup = -1;
    case (urpm_pkg::op_e'(op_bits))
      urpm_pkg::OP_LOAD: begin
        if (stage_len < PathLen) begin
          stage_mem[stage_len] = b;
          stage_len++;
        end else begin
          stage_len = PathLen + 1;
          r.status = urpm_pkg::ST_TOO_LONG;
        end
      end
      urpm_pkg::OP_COMMIT: begin
        len = stage_len;
        stage_len = 0;
        if (len > PathLen) begin
          r.status = urpm_pkg::ST_TOO_LONG;
        end else if (route_cnt >= Routes) begin
          r.status = urpm_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < route_cnt; i++) begin
            if (dup < 0 && path_len[i] == len) begin
              same = 1'b1;
              for (int k = 0; k < len; k++) begin
                if (path_mem[i][k] != stage_mem[k]) same = 1'b0;
              end
              if (same) dup = i;
            end
          end
          if (dup >= 0) begin
            path_handler[dup] = h;
            r.index = 3'(dup);
          end else begin
            for (int k = 0; k < len; k++) path_mem[route_cnt][k] = stage_mem[k];
            path_len[route_cnt]     = len;
            path_handler[route_cnt] = h;
            r.index = 3'(route_cnt);
            route_cnt++;
          end
        end
      end
      urpm_pkg::OP_SEG_BEGIN: begin
        end_segment();
        for (int i = 0; i < route_cnt; i++) begin
          if (alive[i] && offs[i] >= path_len[i]) alive[i] = 1'b0;
        end
        seg_open = 1'b1;
      end
      urpm_pkg::OP_SEG_BYTE: begin
        if (seg_open) begin
          for (int i = 0; i < route_cnt; i++) begin
            if (alive[i]) begin
              if (offs[i] >= path_len[i] || path_mem[i][offs[i]] == urpm_pkg::SlashByte ||
                  path_mem[i][offs[i]] != b) alive[i] = 1'b0;
              else offs[i]++;
            end
          end
        end
      end
      urpm_pkg::OP_MSG_END: begin
        end_segment();
        r.status = urpm_pkg::ST_NOT_FOUND;
        for (int i = 0; i < route_cnt; i++) begin
          if (dup < 0 && alive[i] && offs[i] == path_len[i]) begin
            dup = i;
            r.status  = urpm_pkg::ST_OK;
            r.handler = path_handler[i];
            r.index   = 3'(i);
          end
        end
        if (dup >= 0) hits++;
        else misses++;
        rearm_entries();
      end
      default: begin
      end
    endcase
    if (r.status == urpm_pkg::ST_FULL) full_replies++;
    if (r.status == urpm_pkg::ST_TOO_LONG) too_long_replies++;
    expected_replies.push_back(r);
  endfunction

  // Compares one accepted result word with the oldest pending reply.
  function void check_word(logic [1:0] st, logic [15:0] data);
    route_reply_t want;
    if (expected_replies.size() == 0) begin
      $error("result word with no reply pending: status %0d, data %h", st, data);
      errors++;
      return;
    end
    want = expected_replies.pop_front();
    replies_checked++;
    if (st != want.status) begin
      $error("status: expected %0d, actual %0d", want.status, st);
      errors++;
    end
    if (data[7:0] != want.handler) begin
      $error("found_handler: expected %0d, actual %0d", want.handler, data[7:0]);
      errors++;
    end
    if (data[10:8] != want.index) begin
      $error("entry_index: expected %0d, actual %0d", want.index, data[10:8]);
      errors++;
    end
    if (data[15:11] != '0) begin
      $error("padding: expected 0, actual %0d", data[15:11]);
      errors++;
    end
  endfunction
endclass

module tb_uri_path_route_matcher;
  localparam int unsigned PathLen     = urpm_pkg::MaxPathLenDefault;
  localparam int unsigned RandomWords = 1100;
  localparam int unsigned PoolSize    = 16;
  localparam int unsigned PoolBytes   = PathLen + 4;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        s_valid = 1'b0;
  wire         s_ready;
  logic [15:0] s_data  = '0;   // [7:0] data_byte, [15:8] handler_id
  logic [2:0]  s_user  = '0;   // [2:0] operation
  wire         m_valid;
  logic        m_ready = 1'b0;
  wire  [15:0] m_data;         // [7:0] found_handler, [10:8] entry_index
  wire  [1:0]  m_user;         // [1:0] status

  int unsigned     src_idle_pct  = 8;
  int unsigned     snk_stall_pct = 67;
  int unsigned     words_sent    = 0;
  route_scoreboard table_sb;

  // Paths the stimulus has registered or tried to register, reused to build messages.
  logic [7:0]  pool_mem [PoolSize][PoolBytes];
  int unsigned pool_len [PoolSize];
  int unsigned pool_cnt = 0;

  uri_path_route_matcher #(
    .MAX_ROUTES  (urpm_pkg::MaxRoutesDefault),
    .MAX_PATH_LEN(urpm_pkg::MaxPathLenDefault)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    m_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (s_valid && s_ready) table_sb.apply_word(s_user, s_data[7:0], s_data[15:8]);
      if (m_valid && m_ready) table_sb.check_word(m_user, m_data);
    end
  end

  // Each cycle the sender stays idle with the current idle percentage, then offers the word
  // and holds it until it is taken.
  task automatic send_word(input urpm_pkg::op_e op, input logic [7:0] b,
                           input logic [7:0] h);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {h, b};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    @(posedge clk);
    while (table_sb.expected_replies.size() != 0) @(posedge clk);
  endtask

  // Small alphabet so that paths share prefixes and collide often.
  function automatic logic [7:0] path_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return 8'h61;
    if (r < 55) return 8'h62;
    if (r < 75) return urpm_pkg::SlashByte;
    if (r < 85) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  task automatic register_path();
    int unsigned slot, len, r;
    if (pool_cnt != 0 && $urandom_range(99) < 25) begin
      slot = $urandom_range(pool_cnt - 1);
    end else begin
      slot = (pool_cnt < PoolSize) ? pool_cnt : $urandom_range(PoolSize - 1);
      if (pool_cnt < PoolSize) pool_cnt++;
      r = $urandom_range(99);
      if (r < 8) len = 0;
      else if (r < 18) len = $urandom_range(PathLen - 2, PathLen + 2);
      else len = $urandom_range(1, 6);
      pool_len[slot] = len;
      for (int k = 0; k < len; k++) pool_mem[slot][k] = path_byte();
    end
    for (int k = 0; k < pool_len[slot]; k++) begin
      send_word(urpm_pkg::OP_LOAD, pool_mem[slot][k], 8'($urandom_range(255)));
    end
    send_word(urpm_pkg::OP_COMMIT, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // Splits a pooled path into segments at its slashes, optionally breaks it, and sends it.
  task automatic send_message();
    logic [2:0]  ops [$];
    logic [7:0]  vals [$];
    int unsigned slot, len, pos;
    slot = $urandom_range(pool_cnt - 1);
    len  = pool_len[slot];
    for (int k = 0; k < len; k++) begin
      if (k == 0) begin
        ops.push_back(urpm_pkg::OP_SEG_BEGIN);
        vals.push_back(8'($urandom_range(255)));
      end
      if (pool_mem[slot][k] == urpm_pkg::SlashByte) begin
        // A trailing slash is matched by leaving out the empty last segment.
        if (!(k == len - 1 && $urandom_range(1) == 1)) begin
          ops.push_back(urpm_pkg::OP_SEG_BEGIN);
          vals.push_back(8'($urandom_range(255)));
        end
      end else begin
        ops.push_back(urpm_pkg::OP_SEG_BYTE);
        vals.push_back(pool_mem[slot][k]);
      end
    end
    if ($urandom_range(99) < 30) begin
      pos = (ops.size() == 0) ? 0 : $urandom_range(ops.size() - 1);
      case ($urandom_range(3))
        0: begin
          if (ops.size() != 0) vals[pos] = path_byte();
        end
        1: begin
          if (ops.size() != 0) begin
            ops[pos] = $urandom_range(1) ? urpm_pkg::OP_SEG_BEGIN : urpm_pkg::OP_SEG_BYTE;
          end
        end
        2: begin
          if (ops.size() != 0) begin
            ops.delete(pos);
            vals.delete(pos);
          end
        end
        default: begin
          ops.insert(pos, urpm_pkg::OP_SEG_BYTE);
          vals.insert(pos, path_byte());
        end
      endcase
    end
    for (int k = 0; k < ops.size(); k++) begin
      send_word(urpm_pkg::op_e'(ops[k]), vals[k], 8'($urandom_range(255)));
    end
    send_word(urpm_pkg::OP_MSG_END, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned base, goal, r;
    table_sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: stray segment byte, empty table, empty path, zero and 0xFF bytes,
    // overrun past a path's end, a slash inside a path and a duplicate commit.
    send_word(urpm_pkg::OP_SEG_BYTE, 8'h7A, 8'hFF);
    send_word(urpm_pkg::OP_MSG_END, 8'h00, 8'h00);
    send_word(urpm_pkg::OP_COMMIT, 8'hFF, 8'hFF);
    send_word(urpm_pkg::OP_LOAD, 8'h61, 8'h00);
    send_word(urpm_pkg::OP_LOAD, 8'h00, 8'h00);
    send_word(urpm_pkg::OP_COMMIT, 8'h00, 8'h00);
    send_word(urpm_pkg::OP_LOAD, 8'h61, 8'hFF);
    send_word(urpm_pkg::OP_LOAD, urpm_pkg::SlashByte, 8'hFF);
    send_word(urpm_pkg::OP_LOAD, 8'hFF, 8'hFF);
    send_word(urpm_pkg::OP_COMMIT, 8'h00, 8'hA5);
    send_word(urpm_pkg::OP_MSG_END, 8'hFF, 8'hFF);
    send_word(urpm_pkg::OP_SEG_BEGIN, 8'h00, 8'h00);
    send_word(urpm_pkg::OP_SEG_BYTE, 8'h61, 8'h00);
    send_word(urpm_pkg::OP_SEG_BYTE, 8'h00, 8'h00);
    send_word(urpm_pkg::OP_SEG_BYTE, 8'h00, 8'h00);
    send_word(urpm_pkg::OP_MSG_END, 8'h00, 8'h00);
    send_word(urpm_pkg::OP_SEG_BEGIN, 8'hFF, 8'hFF);
    send_word(urpm_pkg::OP_SEG_BYTE, 8'h61, 8'hFF);
    send_word(urpm_pkg::OP_SEG_BEGIN, 8'hFF, 8'hFF);
    send_word(urpm_pkg::OP_SEG_BYTE, 8'hFF, 8'hFF);
    send_word(urpm_pkg::OP_MSG_END, 8'hFF, 8'hFF);
    send_word(urpm_pkg::OP_LOAD, 8'h61, 8'h00);
    send_word(urpm_pkg::OP_LOAD, 8'h00, 8'h00);
    send_word(urpm_pkg::OP_COMMIT, 8'h00, 8'h5A);

    // Random part in three thirds: sender rarely idle with a slow receiver, the reverse,
    // then full rate. The sender drains all replies between thirds.
    base = words_sent;
    for (int p = 0; p < 3; p++) begin
      src_idle_pct  = (p == 0) ? 8 : (p == 1) ? 67 : 0;
      snk_stall_pct = (p == 0) ? 67 : (p == 1) ? 8 : 0;
      goal = base + (p + 1) * RandomWords / 3;
      while (words_sent < goal) begin
        r = $urandom_range(99);
        if (r < 12) register_path();
        else if (r < 85 && pool_cnt != 0) send_message();
        else send_word(urpm_pkg::op_e'($urandom_range(4)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("run covered %0d words and %0d result words: %0d routes found, %0d misses",
             words_sent, table_sb.replies_checked, table_sb.hits, table_sb.misses);
    $display("%0d table-full and %0d path-too-long replies, %0d routes registered",
             table_sb.full_replies, table_sb.too_long_replies, table_sb.route_cnt);
    if (table_sb.errors == 0 && table_sb.expected_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
